// ----- rtl/mms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants of the min/max stack
// Stack depth, field widths, operation and status codes, stored level format.
// ----------------------------------------------------------------------------
package mms_pkg;

	localparam int DEPTH    = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EMIT
	} state_t;

	// one stack level: the entry and the running extremes from the bottom up to it
	typedef struct packed {
		logic signed [DATA_W-1:0] entry;
		logic signed [DATA_W-1:0] lmax;
		logic signed [DATA_W-1:0] lmin;
	} level_t;

endpackage

// ----- rtl/min_max_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_stack: bounded LIFO of signed 32-bit values with running extremes
// Push, pop or query per transaction; each returns one result transaction.
// ----------------------------------------------------------------------------
// Every input transaction (push, pop or query) yields exactly one result
// transaction carrying the popped value, a status, the fill count, and the
// top, greatest and smallest stored values (all three read 0 when empty).
// Each level lives in a single-port-write, registered-read memory together
// with the running maximum and minimum from the bottom up to that level, so
// the extremes of the whole stack are those of the top level. The top level
// is also held in registers. A push or query therefore needs no memory read:
// the block sustains one such transaction per cycle while the output side
// drains. A successful pop that leaves the stack non-empty must fetch the new
// top level from the memory, whose registered read output is loaded into the
// top registers in a fetch state. The result is held in a pending register
// and moves into the output register once that is free; a new transaction
// is taken while a finished result still waits there. A full push reports
// overflow and an empty pop reports underflow; the stack is left unchanged.
// Mode code 3 acts as a query.
// ----------------------------------------------------------------------------
module min_max_stack (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mms_pkg::MODE_W-1:0]            mode,
	input  logic signed [mms_pkg::DATA_W-1:0]     push_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mms_pkg::DATA_W-1:0]     popped_value,
	output logic [mms_pkg::STATUS_W-1:0]          status,
	output logic [mms_pkg::COUNT_W-1:0]           entry_count,
	output logic signed [mms_pkg::DATA_W-1:0]     top_value,
	output logic signed [mms_pkg::DATA_W-1:0]     greatest_value,
	output logic signed [mms_pkg::DATA_W-1:0]     smallest_value
);

	// control state
	mms_pkg::state_t                   state_q, state_d;
	logic [mms_pkg::CNT_W-1:0]         count_q;
	logic                              out_valid_q;

	// top level copy and pending result fields
	logic signed [mms_pkg::DATA_W-1:0] top_q, tmax_q, tmin_q;
	logic signed [mms_pkg::DATA_W-1:0] popped_q;
	mms_pkg::status_t                  status_q;

	// output register payload
	logic signed [mms_pkg::DATA_W-1:0] out_popped_q, out_top_q, out_max_q, out_min_q;
	logic [mms_pkg::STATUS_W-1:0]      out_status_q;
	logic [mms_pkg::COUNT_W-1:0]       out_count_q;

	// level memory
	mms_pkg::level_t                   mem [mms_pkg::DEPTH];
	mms_pkg::level_t                   rd_q;
	mms_pkg::level_t                   wr_level;
	logic                              mem_we, mem_re;
	logic [mms_pkg::ADDR_W-1:0]        waddr, raddr;

	// decode of the current transaction
	logic                              accept, slot_free, load_out;
	logic                              is_push, is_pop, empty, full;
	logic                              push_ok, pop_ok, need_fetch;
	logic signed [mms_pkg::DATA_W-1:0] new_max, new_min;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == mms_pkg::CNT_W'(mms_pkg::DEPTH));
	assign is_push   = (mode == mms_pkg::MODE_PUSH);
	assign is_pop    = (mode == mms_pkg::MODE_POP);
	assign push_ok   = accept && is_push && !full;
	assign pop_ok    = accept && is_pop && !empty;
	// a pop that leaves at least one level must fetch the new top
	assign need_fetch = pop_ok && (count_q > mms_pkg::CNT_W'(1));

	// extremes for a pushed level: fold the value into those of the current top
	always_comb begin
		if (empty) begin
			new_max = push_value;
			new_min = push_value;
		end else begin
			new_max = (tmax_q < push_value) ? push_value : tmax_q;
			new_min = (push_value < tmin_q) ? push_value : tmin_q;
		end
	end

	assign wr_level = '{entry: push_value, lmax: new_max, lmin: new_min};
	assign mem_we   = push_ok;
	assign waddr    = count_q[mms_pkg::ADDR_W-1:0];
	assign mem_re   = need_fetch;
	assign raddr    = mms_pkg::ADDR_W'(count_q - mms_pkg::CNT_W'(2));

	// Write and read never fall in the same cycle (push and pop are distinct
	// transactions), and a read always falls in a later cycle than any earlier write,
	// so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wr_level;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mms_pkg::S_IDLE, mms_pkg::S_EMIT: begin
				if (accept) begin
					state_d = need_fetch ? mms_pkg::S_FETCH : mms_pkg::S_EMIT;
				end else if (load_out) begin
					state_d = mms_pkg::S_IDLE;
				end
			end
			mms_pkg::S_FETCH: begin
				state_d = mms_pkg::S_EMIT;
			end
			default: begin
				state_d = mms_pkg::S_IDLE;
			end
		endcase
	end

	// FSM outputs: idle always takes a new transaction; emit takes one in the same
	// cycle as the pending result moves into the output register; fetch takes none
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mms_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			mms_pkg::S_EMIT: begin
				load_out = slot_free;
				in_ready = slot_free;
			end
			mms_pkg::S_FETCH: begin
				in_ready = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mms_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push_ok) begin
				count_q <= count_q + mms_pkg::CNT_W'(1);
			end else if (pop_ok) begin
				count_q <= count_q - mms_pkg::CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// top-level copy and pending result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= pop_ok ? top_q : '0;
			if (is_push && full) begin
				status_q <= mms_pkg::STAT_OVERFLOW;
			end else if (is_pop && empty) begin
				status_q <= mms_pkg::STAT_UNDERFLOW;
			end else begin
				status_q <= mms_pkg::STAT_OK;
			end
		end
		if (push_ok) begin
			top_q  <= push_value;
			tmax_q <= new_max;
			tmin_q <= new_min;
		end else if (state_q == mms_pkg::S_FETCH) begin
			top_q  <= rd_q.entry;
			tmax_q <= rd_q.lmax;
			tmin_q <= rd_q.lmin;
		end
	end

	// output register: load the pending result, zero the stack view when empty
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_popped_q <= popped_q;
			out_status_q <= status_q;
			out_count_q  <= mms_pkg::COUNT_W'(count_q);
			out_top_q    <= empty ? '0 : top_q;
			out_max_q    <= empty ? '0 : tmax_q;
			out_min_q    <= empty ? '0 : tmin_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign popped_value   = out_popped_q;
	assign status         = out_status_q;
	assign entry_count    = out_count_q;
	assign top_value      = out_top_q;
	assign greatest_value = out_max_q;
	assign smallest_value = out_min_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mms_pkg::CNT_W'(mms_pkg::DEPTH))
		else $error("fill count beyond stack depth");

	a_fetch_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && need_fetch |=> state_q == mms_pkg::S_FETCH && !in_ready)
		else $error("pop did not stall for the level fetch");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mms_pkg::STAT_OVERFLOW
			|-> entry_count == mms_pkg::COUNT_W'(mms_pkg::DEPTH))
		else $error("overflow reported on a stack that is not full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == '0
			|-> top_value == '0 && greatest_value == '0 && smallest_value == '0)
		else $error("empty stack shows nonzero values");

endmodule
